>>> hdl/clsa_pkg.sv
package clsa_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned FieldPosBits  = 24;
  localparam int unsigned PeriodBits    = 20;
  localparam int unsigned TolBits       = 8;
  localparam int unsigned ChunkBits     = 15;
  localparam int unsigned CapBits       = 8;
  localparam int unsigned CfgIndexBits  = 3;
  localparam int unsigned CfgDataBits   = 24;
  localparam int unsigned DefPositionBits = 24;

  // Register reset values.
  localparam logic [PeriodBits-1:0]          RstStepPeriod = 20'd1250;
  localparam logic signed [FieldPosBits-1:0] RstMinPos     = 24'sh800000;
  localparam logic signed [FieldPosBits-1:0] RstMaxPos     = 24'sh7FFFFF;
  localparam logic [TolBits-1:0]             RstTolerance  = 8'd4;
  localparam logic [ChunkBits-1:0]           RstChunkLimit = 15'd400;
  localparam logic [CapBits-1:0]             RstIterCap    = 8'd53;

  // Configuration register indexes.
  typedef enum logic [CfgIndexBits-1:0] {
    CFG_STEP_PERIOD = 3'd0,
    CFG_MIN_POS     = 3'd1,
    CFG_MAX_POS     = 3'd2,
    CFG_TOLERANCE   = 3'd3,
    CFG_CHUNK_LIMIT = 3'd4,
    CFG_ITER_CAP    = 3'd5
  } cfg_index_t;

  // Input word kinds.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_MOVE = 1'b1;

  typedef enum logic [1:0] {
    OUTC_NONE    = 2'd0,
    OUTC_REACHED = 2'd1,
    OUTC_CAP     = 2'd2
  } outcome_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_CHECK = 3'b010,
    MODE_STEP  = 3'b100
  } mode_t;

  typedef struct packed {
    logic                          kind;
    logic signed [FieldPosBits-1:0] target_steps;
    logic signed [FieldPosBits-1:0] encoder_steps;
    logic                          toolhead_raised;
  } in_word_t;

  typedef struct packed {
    logic                          step_level;
    logic                          direction_up;
    logic signed [FieldPosBits-1:0] position;
    logic                          busy_res;
    logic                          finished;
    logic [1:0]                    outcome;
  } out_word_t;

  typedef struct packed {
    logic [PeriodBits-1:0]          step_period;
    logic signed [FieldPosBits-1:0] min_pos;
    logic signed [FieldPosBits-1:0] max_pos;
    logic [TolBits-1:0]             tolerance;
    logic [ChunkBits-1:0]           chunk_limit;
    logic [CapBits-1:0]             iter_cap;
  } cfg_t;

endpackage

>>> hdl/clsa_core.sv
module clsa_core #(
  parameter int unsigned POSITION_BITS = clsa_pkg::DefPositionBits
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  clsa_pkg::in_word_t   item,
  input  clsa_pkg::cfg_t       cfg,
  output clsa_pkg::out_word_t  result
);
  import clsa_pkg::*;

  mode_t                            mode_r, mode_nxt;
  logic                             pulse_r, pulse_nxt;
  logic [ChunkBits-1:0]             steps_r, steps_nxt;
  logic                             up_r, up_nxt;
  logic signed [POSITION_BITS-1:0]  pos_r, pos_nxt;
  logic signed [FieldPosBits-1:0]   target_r, target_nxt;
  logic [CapBits-1:0]               chunks_r, chunks_nxt;
  logic [PeriodBits-1:0]            tick_r, tick_nxt;

  logic signed [FieldPosBits-1:0]   clamp_lo, clamped;
  logic signed [FieldPosBits:0]     err;
  logic [FieldPosBits:0]            mag;
  logic [ChunkBits-1:0]             chunk_n;
  logic [PeriodBits-1:0]            period;
  logic                             timer_hit;
  logic                             fin;
  outcome_t                         outc;

  // The upper limit is applied last, so it wins when the limits cross.
  assign clamp_lo = (item.target_steps < cfg.min_pos) ? cfg.min_pos : item.target_steps;
  assign clamped  = (clamp_lo > cfg.max_pos) ? cfg.max_pos : clamp_lo;

  assign err     = (FieldPosBits+1)'(target_r) - (FieldPosBits+1)'(item.encoder_steps);
  assign mag     = err[FieldPosBits] ? unsigned'(-err) : unsigned'(err);
  assign chunk_n = (mag > (FieldPosBits+1)'(cfg.chunk_limit)) ? cfg.chunk_limit
                                                              : mag[ChunkBits-1:0];

  assign period    = (cfg.step_period == '0) ? PeriodBits'(1) : cfg.step_period;
  assign timer_hit = ({1'b0, tick_r} + (PeriodBits+1)'(1)) >= {1'b0, period};

  always_comb begin
    mode_nxt   = mode_r;
    pulse_nxt  = pulse_r;
    steps_nxt  = steps_r;
    up_nxt     = up_r;
    pos_nxt    = pos_r;
    target_nxt = target_r;
    chunks_nxt = chunks_r;
    tick_nxt   = tick_r;
    fin        = 1'b0;
    outc       = OUTC_NONE;
    if (accept) begin
      if (item.kind == KIND_MOVE) begin
        if (mode_r == MODE_IDLE) begin
          target_nxt = clamped;
          chunks_nxt = '0;
          mode_nxt   = MODE_CHECK;
        end
      end else begin
        case (mode_r)
          MODE_CHECK: begin
            if (chunks_r >= cfg.iter_cap) begin
              pos_nxt  = POSITION_BITS'(item.encoder_steps);
              mode_nxt = MODE_IDLE;
              fin      = 1'b1;
              outc     = OUTC_CAP;
            end else if (mag <= (FieldPosBits+1)'(cfg.tolerance)) begin
              pos_nxt  = POSITION_BITS'(item.encoder_steps);
              mode_nxt = MODE_IDLE;
              fin      = 1'b1;
              outc     = OUTC_REACHED;
            end else begin
              chunks_nxt = chunks_r + CapBits'(1);
              // A lowered toolhead still uses up one iteration.
              if (item.toolhead_raised && chunk_n != '0) begin
                up_nxt    = ~err[FieldPosBits];
                steps_nxt = chunk_n;
                pulse_nxt = 1'b0;
                tick_nxt  = '0;
                mode_nxt  = MODE_STEP;
              end
            end
          end
          MODE_STEP: begin
            if (timer_hit) begin
              tick_nxt = '0;
              if (!pulse_r && steps_r != '0) begin
                pulse_nxt = 1'b1;
              end else if (pulse_r) begin
                pulse_nxt = 1'b0;
                if (steps_r != '0) begin
                  steps_nxt = steps_r - ChunkBits'(1);
                  pos_nxt   = up_r ? pos_r + POSITION_BITS'(1) : pos_r - POSITION_BITS'(1);
                end
                if (steps_r <= ChunkBits'(1)) begin
                  mode_nxt = MODE_CHECK;
                end
              end else begin
                mode_nxt = MODE_CHECK;
              end
            end else begin
              tick_nxt = tick_r + PeriodBits'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pulse_r  <= 1'b0;
      steps_r  <= '0;
      up_r     <= 1'b1;
      pos_r    <= '0;
      target_r <= '0;
      chunks_r <= '0;
      tick_r   <= '0;
    end else begin
      mode_r   <= mode_nxt;
      pulse_r  <= pulse_nxt;
      steps_r  <= steps_nxt;
      up_r     <= up_nxt;
      pos_r    <= pos_nxt;
      target_r <= target_nxt;
      chunks_r <= chunks_nxt;
      tick_r   <= tick_nxt;
    end
  end

  always_comb begin
    result.step_level   = pulse_nxt;
    result.direction_up = up_nxt;
    result.position     = FieldPosBits'(pos_nxt);
    result.busy_res     = (mode_nxt != MODE_IDLE);
    result.finished     = fin;
    result.outcome      = outc;
  end

endmodule

>>> hdl/closed_loop_stepper_axis_top.sv
// Closed-loop step/direction axis with encoder correction.
// The result word for an input word is registered into the output register, or the skid entry.
// Throughput: one word per cycle unless stalled; state updates in the same cycle as accept.
// Reset: synchronous, active low; clears the axis state and output buffer, loads config defaults.
// A two-entry output buffer keeps input flowing for one more word while the output is stalled.
module closed_loop_stepper_axis_top #(
  parameter int unsigned POSITION_BITS = clsa_pkg::DefPositionBits
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  clsa_pkg::in_word_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output clsa_pkg::out_word_t                    out_data,
  input  logic                                   cfg_we,
  input  logic [clsa_pkg::CfgIndexBits-1:0]      cfg_index,
  input  logic [clsa_pkg::CfgDataBits-1:0]       cfg_data
);
  import clsa_pkg::*;

  // Configuration registers; to be written only while no word is in flight (the block does
  // not enforce it). The axis may be mid-move; new values apply from the next word.
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_period <= RstStepPeriod;
      cfg_r.min_pos     <= RstMinPos;
      cfg_r.max_pos     <= RstMaxPos;
      cfg_r.tolerance   <= RstTolerance;
      cfg_r.chunk_limit <= RstChunkLimit;
      cfg_r.iter_cap    <= RstIterCap;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_PERIOD: cfg_r.step_period <= cfg_data[PeriodBits-1:0];
        CFG_MIN_POS:     cfg_r.min_pos     <= cfg_data[FieldPosBits-1:0];
        CFG_MAX_POS:     cfg_r.max_pos     <= cfg_data[FieldPosBits-1:0];
        CFG_TOLERANCE:   cfg_r.tolerance   <= cfg_data[TolBits-1:0];
        CFG_CHUNK_LIMIT: cfg_r.chunk_limit <= cfg_data[ChunkBits-1:0];
        CFG_ITER_CAP:    cfg_r.iter_cap    <= cfg_data[CapBits-1:0];
        default: begin
        end
      endcase
    end
  end

  // An input word is taken whenever the skid entry is free.
  logic      accept;
  out_word_t result;
  logic      skid_valid_r;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;

  clsa_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .cfg    (cfg_r),
    .result (result)
  );

  // Output register plus skid entry. The skid fills only when the output
  // register is held by a stall and a new word arrives in the same cycle.
  logic      out_valid_r;
  out_word_t out_data_r;
  out_word_t skid_data_r;
  logic      out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : result;
    end
    if (!out_free && accept) begin
      skid_data_r <= result;
    end
  end

endmodule

>>> verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import clsa_pkg::*;

  // If nothing is accepted on either side for this many cycles, the block is hung.
  localparam int QuietLimit = 2000;
  // Cycles to let pass after the last result before the verdict.
  localparam int SettleCycles = 8;
  // Random phases and the number of effective words in each of them.
  localparam int PhaseCount = 12;
  localparam int PhaseWords = 90;
  localparam int SlowPhaseWords = 330;

  // One row of the directed table: either a full register load or one input word.
  // When known is set, the expected result is typed into the row. Otherwise the
  // predictor supplies it.
  typedef struct {
    bit        set_regs;
    cfg_t      regs;
    in_word_t  word;
    bit        known;
    out_word_t want;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  in_word_t                in_data = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  out_word_t               out_data;
  logic                    cfg_we = 1'b0;
  logic [CfgIndexBits-1:0] cfg_index = '0;
  logic [CfgDataBits-1:0]  cfg_data = '0;

  // Results still owed by the block, oldest first.
  out_word_t expected_axis_words[$];
  stim_row_t directed[$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  quiet_cycles = 0;
  // While set, neither side idles or stalls.
  bit  steady = 1'b0;

  // Shadow of the axis state and of the register file, kept by the predictor.
  mode_t              ax_mode = MODE_IDLE;
  logic               ax_pulse = 1'b0;
  logic [14:0]        ax_left = '0;
  logic               ax_up = 1'b1;
  logic signed [23:0] ax_pos = '0;
  logic signed [23:0] ax_goal = '0;
  logic [7:0]         ax_chunks = '0;
  logic [19:0]        ax_ticks = '0;
  cfg_t               regs = '{RstStepPeriod, RstMinPos, RstMaxPos,
                               RstTolerance, RstChunkLimit, RstIterCap};

  closed_loop_stepper_axis_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advances the shadow axis by one input word and returns the result word it produces.
  // A move command only arms the loop when the axis is idle. Each tick in the check
  // phase runs one loop iteration, and each tick in the step phase advances the step
  // timer, which toggles the pulse on every period and moves the position when a pulse
  // completes.
  function automatic out_word_t axis_step(input in_word_t w);
    out_word_t          r;
    logic signed [23:0] t;
    int                 err;
    int                 mag;
    int                 lim;
    int unsigned        period;
    r = '0;
    if (w.kind == KIND_MOVE) begin
      if (ax_mode == MODE_IDLE) begin
        // Raise to the lower limit first, then lower to the upper one, so with
        // inverted limits the upper limit wins.
        t = w.target_steps;
        if ($signed(t) < $signed(regs.min_pos)) t = regs.min_pos;
        if ($signed(t) > $signed(regs.max_pos)) t = regs.max_pos;
        ax_goal = t;
        ax_chunks = '0;
        ax_mode = MODE_CHECK;
      end
    end else if (ax_mode == MODE_CHECK) begin
      err = int'($signed(ax_goal)) - int'($signed(w.encoder_steps));
      mag = (err < 0) ? -err : err;
      // The iteration cap is tested before the tolerance.
      if (ax_chunks >= regs.iter_cap) begin
        ax_pos = w.encoder_steps;
        ax_mode = MODE_IDLE;
        r.finished = 1'b1;
        r.outcome = OUTC_CAP;
      end else if (mag <= int'(regs.tolerance)) begin
        ax_pos = w.encoder_steps;
        ax_mode = MODE_IDLE;
        r.finished = 1'b1;
        r.outcome = OUTC_REACHED;
      end else begin
        lim = (mag > int'(regs.chunk_limit)) ? int'(regs.chunk_limit) : mag;
        // A chunk counts even when the toolhead is down or the chunk is empty.
        ax_chunks = ax_chunks + 8'd1;
        if (w.toolhead_raised && lim > 0) begin
          ax_up = (err > 0);
          ax_left = lim[14:0];
          ax_pulse = 1'b0;
          ax_ticks = '0;
          ax_mode = MODE_STEP;
        end
      end
    end else if (ax_mode == MODE_STEP) begin
      // A period of zero behaves like a period of one.
      period = (regs.step_period == '0) ? 1 : int'(regs.step_period);
      if (int'(ax_ticks) + 1 >= period) begin
        ax_ticks = '0;
        if (!ax_pulse && ax_left != '0) begin
          ax_pulse = 1'b1;
        end else if (ax_pulse) begin
          ax_pulse = 1'b0;
          if (ax_left != '0) begin
            ax_left = ax_left - 15'd1;
            ax_pos = ax_up ? ax_pos + 24'sd1 : ax_pos - 24'sd1;
          end
          if (ax_left == '0) ax_mode = MODE_CHECK;
        end else begin
          ax_mode = MODE_CHECK;
        end
      end else begin
        ax_ticks = ax_ticks + 20'd1;
      end
    end
    r.step_level = ax_pulse;
    r.direction_up = ax_up;
    r.position = ax_pos;
    r.busy_res = (ax_mode != MODE_IDLE);
    return r;
  endfunction

  // Directed words carry the same value in both position fields; only the one that
  // matters for the kind of word is used by the block.
  function automatic stim_row_t item_row(input logic kind, input int value,
                                         input logic raised);
    stim_row_t row;
    row = '{default: '0};
    row.word = {kind, value[23:0], value[23:0], raised};
    return row;
  endfunction

  // A directed word whose result can be read off directly. Every such row here has
  // the pulse low and the direction up.
  function automatic stim_row_t known_row(input logic kind, input int value,
                                          input logic raised, input int pos,
                                          input logic busy, input logic fin,
                                          input outcome_t oc);
    stim_row_t row;
    row = item_row(kind, value, raised);
    row.known = 1'b1;
    row.want = {1'b0, 1'b1, pos[23:0], busy, fin, oc};
    return row;
  endfunction

  function automatic stim_row_t regs_row(input int period, input int lo, input int hi,
                                         input int tol, input int chunk, input int cap);
    stim_row_t row;
    row = '{default: '0};
    row.set_regs = 1'b1;
    row.regs = {period[19:0], lo[23:0], hi[23:0], tol[7:0], chunk[14:0], cap[7:0]};
    return row;
  endfunction

  // Builds the next random word from the shadow state. Most words form proper move
  // sequences: a move to a target near the current position, followed by ticks whose
  // encoder follows the logical position with a little noise. A small share is pure
  // noise, but only while chunks are small, so that one bad encoder reading cannot
  // start a move that outlasts the run.
  function automatic in_word_t next_axis_word(input int spread);
    in_word_t w;
    int       roll;
    w.kind = 1'($urandom_range(1));
    w.target_steps = 24'($urandom);
    w.encoder_steps = 24'($urandom);
    w.toolhead_raised = 1'($urandom_range(1));
    roll = int'($urandom_range(99));
    if (roll < 6 && regs.chunk_limit <= 15'd64) return w;
    if (ax_mode == MODE_IDLE) begin
      if (roll < 70) begin
        w.kind = KIND_MOVE;
        w.target_steps = 24'(int'(ax_pos) + int'($urandom_range(2 * spread)) - spread);
      end else begin
        w.kind = KIND_TICK;
        w.encoder_steps = 24'(int'(ax_pos) + int'($urandom_range(4)) - 2);
      end
    end else if (roll < 18) begin
      // A command while busy must be ignored.
      w.kind = KIND_MOVE;
    end else begin
      w.kind = KIND_TICK;
      if (roll < 93 || regs.chunk_limit > 15'd64)
        w.encoder_steps = 24'(int'(ax_pos) + int'($urandom_range(4)) - 2);
      w.toolhead_raised = ($urandom_range(99) < 88);
    end
    return w;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50) $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d, %s: got %0h, want %0h",
                              results_seen, name, got, want));
  endtask

  // Presents one word and holds it until it is accepted. On acceptance the predictor
  // advances and the expected result is queued. The word is effective when the block
  // does not simply ignore it: a move while idle or a tick while busy.
  task automatic send_word(input in_word_t w, input bit known, input out_word_t want,
                           output bit effective);
    out_word_t predicted;
    while (!steady && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!(in_valid && !in_stall));
    effective = ((w.kind == KIND_MOVE) == (ax_mode == MODE_IDLE));
    predicted = axis_step(w);
    expected_axis_words.push_back(known ? want : predicted);
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_axis_words.size() != 0);
  endtask

  // Loads all six registers, one per cycle, with the block drained. The axis itself
  // may still be in the middle of a move; the new values take effect on the next word.
  task automatic load_regs(input cfg_t c);
    drain_results();
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_STEP_PERIOD;
    cfg_data <= 24'(c.step_period);
    @(posedge clk);
    cfg_index <= CFG_MIN_POS;
    cfg_data <= c.min_pos;
    @(posedge clk);
    cfg_index <= CFG_MAX_POS;
    cfg_data <= c.max_pos;
    @(posedge clk);
    cfg_index <= CFG_TOLERANCE;
    cfg_data <= 24'(c.tolerance);
    @(posedge clk);
    cfg_index <= CFG_CHUNK_LIMIT;
    cfg_data <= 24'(c.chunk_limit);
    @(posedge clk);
    cfg_index <= CFG_ITER_CAP;
    cfg_data <= 24'(c.iter_cap);
    @(posedge clk);
    cfg_we <= 1'b0;
    regs = c;
  endtask

  // The result side stalls at random, except during the steady stretch.
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 12);
  end

  // Result checker and activity counter for the watchdog. Every accepted result is
  // compared field by field with the oldest expectation.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_axis_words.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_axis_words.pop_front();
          check_field("step_level", out_data.step_level, want.step_level);
          check_field("direction_up", out_data.direction_up, want.direction_up);
          check_field("position", out_data.position, want.position);
          check_field("busy_res", out_data.busy_res, want.busy_res);
          check_field("finished", out_data.finished, want.finished);
          check_field("outcome", out_data.outcome, want.outcome);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    cfg_t      c;
    in_word_t  w;
    out_word_t unused;
    bit        effective;
    int        p;
    int        quota;
    int        done;
    int        spread;

    unused = '0;

    // Reset values: a tick while idle, a move to the top of the range, a second move
    // that must be ignored, and arrival exactly at the target.
    directed.push_back(known_row(KIND_TICK, 0, 1'b0, 0, 1'b0, 1'b0, OUTC_NONE));
    directed.push_back(known_row(KIND_MOVE, 8388607, 1'b0, 0, 1'b1, 1'b0, OUTC_NONE));
    directed.push_back(known_row(KIND_MOVE, -8388608, 1'b1, 0, 1'b1, 1'b0, OUTC_NONE));
    directed.push_back(known_row(KIND_TICK, 8388607, 1'b1, 8388607, 1'b0, 1'b1,
                                 OUTC_REACHED));
    // Move to the bottom of the range, arriving with an error equal to the tolerance.
    directed.push_back(known_row(KIND_MOVE, -8388608, 1'b0, 8388607, 1'b1, 1'b0,
                                 OUTC_NONE));
    directed.push_back(known_row(KIND_TICK, -8388604, 1'b1, -8388604, 1'b0, 1'b1,
                                 OUTC_REACHED));
    // Zero step period, single-step chunks and a cap of two: the target is clamped,
    // the first chunk is skipped with the toolhead down, the second is stepped, and
    // the cap ends the move.
    directed.push_back(regs_row(0, -10, 10, 0, 1, 2));
    directed.push_back(item_row(KIND_MOVE, 100, 1'b1));
    directed.push_back(item_row(KIND_TICK, 0, 1'b0));
    directed.push_back(item_row(KIND_TICK, 0, 1'b1));
    directed.push_back(item_row(KIND_TICK, 0, 1'b1));
    directed.push_back(item_row(KIND_TICK, 0, 1'b1));
    directed.push_back(known_row(KIND_TICK, 9, 1'b1, 9, 1'b0, 1'b1, OUTC_CAP));
    // A cap of zero ends the move on the first check even with no error.
    directed.push_back(regs_row(0, -10, 10, 0, 0, 0));
    directed.push_back(item_row(KIND_MOVE, -100, 1'b0));
    directed.push_back(known_row(KIND_TICK, -10, 1'b1, -10, 1'b0, 1'b1, OUTC_CAP));
    // Inverted limits, an empty chunk and the widest tolerance.
    directed.push_back(regs_row(1, 5, -5, 255, 0, 255));
    directed.push_back(item_row(KIND_MOVE, 0, 1'b1));
    directed.push_back(item_row(KIND_TICK, 1000, 1'b1));
    directed.push_back(known_row(KIND_TICK, 250, 1'b1, 250, 1'b0, 1'b1, OUTC_REACHED));
    // A very long step period and a large chunk limit: the axis is left stepping, and the first
    // random phase picks it up with a short period.
    directed.push_back(regs_row(1000000, -8388608, 8388607, 0, 20000, 1));
    directed.push_back(item_row(KIND_MOVE, 3, 1'b0));
    directed.push_back(item_row(KIND_TICK, 0, 1'b1));
    directed.push_back(item_row(KIND_TICK, 0, 1'b1));
    directed.push_back(item_row(KIND_TICK, 0, 1'b1));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].set_regs)
        load_regs(directed[i].regs);
      else
        send_word(directed[i].word, directed[i].known, directed[i].want, effective);
    end

    // Random phases. Most use short step periods and small chunks so that moves run
    // to completion; a few pin registers to their extremes.
    for (p = 0; p < PhaseCount; p++) begin
      c.step_period = 20'($urandom_range(3));
      c.min_pos = RstMinPos;
      c.max_pos = RstMaxPos;
      c.tolerance = 8'($urandom_range(5));
      c.chunk_limit = 15'($urandom_range(30, 1));
      c.iter_cap = 8'($urandom_range(30, 3));
      case (p)
        1: begin
          // Slowest period in the normal range, with tiny moves.
          c.step_period = 20'd50;
          c.chunk_limit = 15'd2;
          c.tolerance = 8'd1;
        end
        3: begin
          c.tolerance = 8'd255;
          c.chunk_limit = 15'd20000;
          c.iter_cap = 8'd255;
        end
        5: begin
          c.iter_cap = 8'd1;
          c.chunk_limit = 15'd1;
        end
        7: begin
          // Inverted window around the current position.
          c.min_pos = 24'(int'(ax_pos) + 8);
          c.max_pos = 24'(int'(ax_pos) - 8);
        end
        9: begin
          // Narrow window, so that most targets get clamped.
          c.min_pos = 24'(int'(ax_pos) - 6);
          c.max_pos = 24'(int'(ax_pos) + 6);
        end
        10: begin
          c.step_period = 20'd1;
          c.chunk_limit = 15'd1;
          c.tolerance = 8'd0;
        end
        default: ;
      endcase
      load_regs(c);
      spread = int'(c.tolerance) + 2 * int'(c.chunk_limit) + 3;
      if (spread > 300) spread = 300;
      quota = (p == 1) ? SlowPhaseWords : PhaseWords;
      steady = (p == 6);
      done = 0;
      while (done < quota) begin
        // Now and then the sender holds off until the block has caught up.
        if ($urandom_range(199) == 0) drain_results();
        w = next_axis_word(spread);
        send_word(w, 1'b0, unused, effective);
        if (effective) done++;
      end
      steady = 1'b0;
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/clsa_pkg.sv
hdl/clsa_core.sv
hdl/closed_loop_stepper_axis_top.sv
verif/tb_top.sv
